FILE: design/assert_macros.svh
// Assertion macros shared by the RTL modules.
// No dependencies; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define AST_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Check that cons holds in the cycle after ante.
`define AST_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define AST_IMPL(lbl, clk, rst, ante, cons)
`define AST_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: design/uetl_pkg.sv
// Shared types, codes and constants of the ultrasonic tank level core.
// No dependencies; imported by the top level, uetl_front and uetl_back.
`default_nettype none

package uetl_pkg;

  // Defaults for the top-level parameters
  localparam int COUNT_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Field and register widths
  localparam int STATUS_W   = 2;
  localparam int LEVEL_W    = 10;
  localparam int COLOUR_W   = 2;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TLOW_W     = 8;
  localparam int THIGH_W    = 8;
  localparam int TIMEOUT_W  = 16;
  localparam int HEIGHT_W   = 14;

  // Level arithmetic: full = 58 * H (< 2^20), numerator < 1000 * full (< 2^30)
  localparam int US_PER_MM_X10 = 58;
  localparam int WIDTH_SCALE   = 10;
  localparam int LEVEL_SCALE   = 1000;
  localparam int FULL_W        = 20;
  localparam int NUM_W         = 30;
  localparam int DIV_STEPS     = 10;
  localparam int STEP_W        = 4;

  // Reset values of the configuration registers
  localparam logic [TLOW_W-1:0]    TLOW_RST    = TLOW_W'(2);
  localparam logic [THIGH_W-1:0]   THIGH_RST   = THIGH_W'(10);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(30000);
  localparam logic [HEIGHT_W-1:0]  HEIGHT_RST  = HEIGHT_W'(118);

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_TRIG_LOW  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_TRIG_HIGH = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT   = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_TANK_H    = REG_IDX_W'(3);

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK         = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_NO_RISE    = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_TOO_LONG   = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] ST_ZERO_WIDTH = STATUS_W'(3);

  // Colour codes and band limits
  localparam logic [COLOUR_W-1:0] COL_OFF    = COLOUR_W'(0);
  localparam logic [COLOUR_W-1:0] COL_RED    = COLOUR_W'(1);
  localparam logic [COLOUR_W-1:0] COL_YELLOW = COLOUR_W'(2);
  localparam logic [COLOUR_W-1:0] COL_GREEN  = COLOUR_W'(3);
  localparam logic [LEVEL_W-1:0]  RED_MAX    = LEVEL_W'(200);
  localparam logic [LEVEL_W-1:0]  YELLOW_MAX = LEVEL_W'(700);
  localparam logic [LEVEL_W-1:0]  GREEN_MAX  = LEVEL_W'(999);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LOW,
    PH_HIGH,
    PH_RISE,
    PH_ECHO
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCALE,
    BK_PREP,
    BK_DIV
  } back_state_t;

  typedef struct packed {
    logic action;
    logic echo_level;
  } item_t;

  typedef struct packed {
    logic                trigger_out;
    logic                busy_res;
    logic                done_res;
    logic [STATUS_W-1:0] status;
    logic [LEVEL_W-1:0]  level_tenths;
    logic [COLOUR_W-1:0] led_colour;
  } res_t;

  // Per-tick outcome handed from the sequencer to the level unit
  typedef struct packed {
    logic                trigger_out;
    logic                busy_res;
    logic                done_res;
    logic [STATUS_W-1:0] status;
  } tick_t;

endpackage

`default_nettype wire

FILE: design/ultrasonic_echo_tank_level_core.sv
// Top level of the ultrasonic tank level core: configuration registers,
// sequencer, queue and level unit. Depends on uetl_pkg and all uetl_* modules.
//
//   port group   direction  handshake          word
//   item         in         push / full        uetl_pkg::item_t (action, echo_level)
//   result       out        empty / pop        uetl_pkg::res_t (trigger .. led_colour)
//   wr_*         in         wr_en              wr_index, wr_data
//
// The sequencer takes one tick word per cycle while the 4-word queue has room.
// A word that does not finish a good measurement moves into the result register
// at the edge that pops it from the queue; one that does passes through the scale
// and prepare states and then the restoring divider that forms the level, or
// skips the divider when the level comes out zero.
// Reset is synchronous and needs no clearing pass. Input stalls when the queue
// fills; the level unit holds while the result word waits for pop.
`default_nettype none

module ultrasonic_echo_tank_level_core #(
  parameter int COUNT_BITS  = uetl_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = uetl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  uetl_pkg::item_t                 item,
  output logic                            empty,
  input  logic                            pop,
  output uetl_pkg::res_t                  result,
  input  logic                            wr_en,
  input  logic [uetl_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [uetl_pkg::CFG_DATA_W-1:0] wr_data
);
  import uetl_pkg::*;

  localparam int Q_W = $bits(tick_t) + COUNT_BITS;

  logic [TLOW_W-1:0]     trig_low;
  logic [THIGH_W-1:0]    trig_high;
  logic [TIMEOUT_W-1:0]  timeout;
  logic [HEIGHT_W-1:0]   tank_h;
  tick_t                 f_tick, b_tick;
  logic [COUNT_BITS-1:0] f_width, b_width;
  logic                  f_push, q_full, q_empty, q_pop;
  logic [Q_W-1:0]        q_rd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      trig_low  <= TLOW_RST;
      trig_high <= THIGH_RST;
      timeout   <= TIMEOUT_RST;
      tank_h    <= HEIGHT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TRIG_LOW:  trig_low  <= wr_data[TLOW_W-1:0];
        REG_TRIG_HIGH: trig_high <= wr_data[THIGH_W-1:0];
        REG_TIMEOUT:   timeout   <= wr_data[TIMEOUT_W-1:0];
        REG_TANK_H:    tank_h    <= wr_data[HEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  uetl_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .trig_low  (trig_low),
    .trig_high (trig_high),
    .timeout   (timeout),
    .q_push    (f_push),
    .q_full    (q_full),
    .q_tick    (f_tick),
    .q_width   (f_width)
  );

  uetl_queue #(
    .DATA_W (Q_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (f_push),
    .full    (q_full),
    .wr_data ({f_tick, f_width}),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd)
  );

  assign {b_tick, b_width} = q_rd;

  uetl_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_tick  (b_tick),
    .q_width (b_width),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .tank_h  (tank_h),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

`default_nettype wire

FILE: design/uetl_front.sv
// Front sequencer: runs the trigger/echo phases, one tick word per cycle
// unless q_full. Feeds uetl_queue; needs uetl_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module uetl_front #(
  parameter int COUNT_BITS = uetl_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  uetl_pkg::item_t                  item,
  input  logic [uetl_pkg::TLOW_W-1:0]      trig_low,
  input  logic [uetl_pkg::THIGH_W-1:0]     trig_high,
  input  logic [uetl_pkg::TIMEOUT_W-1:0]   timeout,
  output logic                             q_push,
  input  logic                             q_full,
  output uetl_pkg::tick_t                  q_tick,
  output logic [COUNT_BITS-1:0]            q_width
);
  import uetl_pkg::*;

  localparam int CMP_W = (COUNT_BITS > TIMEOUT_W) ? COUNT_BITS : TIMEOUT_W;

  phase_t                phase, phase_next, ph_s0, ph_s1, ph_s2;
  logic [COUNT_BITS-1:0] ticks, ticks_next, t0, t1, t2;
  logic [COUNT_BITS-1:0] width, width_next, ew0;
  logic                  accept, started, low_end, high_end, rise_fail, echo_fail;

  assign accept = push && !q_full;
  assign full   = q_full;
  assign q_push = accept;

  // Walk the start, low-end and high-end transitions of this tick
  assign started  = (phase == PH_IDLE) && item.action;
  assign ph_s0    = started ? PH_LOW : phase;
  assign t0       = started ? '0 : ticks;
  assign ew0      = started ? '0 : width;
  assign low_end  = (ph_s0 == PH_LOW) && (t0 >= COUNT_BITS'(trig_low));
  assign ph_s1    = low_end ? PH_HIGH : ph_s0;
  assign t1       = low_end ? '0 : t0;
  assign high_end = (ph_s1 == PH_HIGH) && (t1 >= COUNT_BITS'(trig_high));
  assign ph_s2    = high_end ? PH_RISE : ph_s1;
  assign t2       = high_end ? '0 : t1;

  // Timeout and counter limit checks
  assign rise_fail = (CMP_W'(t2) >= CMP_W'(timeout)) || (&t2);
  assign echo_fail = (CMP_W'(ew0) >= CMP_W'(timeout)) || (&ew0);

  // Next phase and counters
  always_comb begin
    phase_next = ph_s2;
    ticks_next = t2;
    width_next = ew0;
    unique case (ph_s2)
      PH_IDLE: begin
      end
      PH_LOW, PH_HIGH: begin
        ticks_next = t2 + 1'b1;
      end
      PH_RISE: begin
        if (item.echo_level) begin
          phase_next = PH_ECHO;
          width_next = COUNT_BITS'(1);
        end else if (rise_fail) begin
          phase_next = PH_IDLE;
          ticks_next = '0;
        end else begin
          ticks_next = t2 + 1'b1;
        end
      end
      PH_ECHO: begin
        if (item.echo_level && !echo_fail) begin
          width_next = ew0 + 1'b1;
        end else begin
          phase_next = PH_IDLE;
          ticks_next = '0;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        ticks_next = '0;
      end
    endcase
  end

  // Tick outcome
  always_comb begin
    q_tick             = '0;
    q_tick.trigger_out = (ph_s2 == PH_HIGH);
    q_tick.busy_res    = (phase_next != PH_IDLE);
    q_width            = width_next;
    unique case (ph_s2)
      PH_RISE: begin
        if (!item.echo_level && rise_fail) begin
          q_tick.done_res = 1'b1;
          q_tick.status   = ST_NO_RISE;
        end
      end
      PH_ECHO: begin
        if (item.echo_level) begin
          if (echo_fail) begin
            q_tick.done_res = 1'b1;
            q_tick.status   = ST_TOO_LONG;
          end
        end else begin
          q_tick.done_res = 1'b1;
          q_tick.status   = (ew0 == '0) ? ST_ZERO_WIDTH : ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // Advance on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      ticks <= '0;
      width <= '0;
    end else if (accept) begin
      phase <= phase_next;
      ticks <= ticks_next;
      width <= width_next;
    end
  end

  `AST_NEXT(a_idle_holds, clk, rst, accept && phase == PH_IDLE && !item.action, phase == PH_IDLE)
  `AST_IMPL(a_done_not_busy, clk, rst, accept && q_tick.done_res, phase_next == PH_IDLE)

endmodule

`default_nettype wire

FILE: design/uetl_queue.sv
// Small first-in first-out queue between the sequencer and the level unit.
// Depends on assert_macros.svh only.
`default_nettype none
`include "assert_macros.svh"

module uetl_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              pop,
  output logic              empty,
  output logic [DATA_W-1:0] rd_data
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW-1:0]     wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              wr_ok, rd_ok;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign wr_ok   = push && !full;
  assign rd_ok   = pop && !empty;
  assign rd_data = mem[rd_ptr];

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_ok) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_ok) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_ok && !rd_ok) begin
        count <= count + 1'b1;
      end else if (rd_ok && !wr_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  `AST_NEXT(a_drain, clk, rst, rd_ok && !wr_ok, count == $past(count) - CNT_W'(1))

endmodule

`default_nettype wire

FILE: design/uetl_back.sv
// Level unit: turns finished echo widths into fill level and colour and
// holds the result word. Depends on uetl_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module uetl_back #(
  parameter int COUNT_BITS = uetl_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  uetl_pkg::tick_t                q_tick,
  input  logic [COUNT_BITS-1:0]          q_width,
  input  logic                           q_empty,
  output logic                           q_pop,
  input  logic [uetl_pkg::HEIGHT_W-1:0]  tank_h,
  output logic                           empty,
  input  logic                           pop,
  output uetl_pkg::res_t                 result
);
  import uetl_pkg::*;

  localparam int USED_W = COUNT_BITS + 4;
  localparam int CMP_W  = (USED_W > FULL_W) ? USED_W : FULL_W;

  back_state_t           state, state_next;
  tick_t                 tick_hold;
  logic [COUNT_BITS-1:0] width_hold;
  logic [FULL_W-1:0]     full_r, diff;
  logic [CMP_W-1:0]      used_r;
  logic [NUM_W-1:0]      rem, dvs, num;
  logic [LEVEL_W-1:0]    quo, quo_step, fin_level, level_held;
  logic [COLOUR_W-1:0]   colour_held, colour_new;
  logic [STEP_W-1:0]     step;
  logic                  out_valid, take, needs_div, zero_level, fits, finish, load;
  res_t                  res_next;

  assign empty = !out_valid;

  // Arithmetic of the level path
  assign zero_level = (used_r >= CMP_W'(full_r));
  assign diff       = full_r - used_r[FULL_W-1:0];
  assign num        = NUM_W'(diff) * NUM_W'(LEVEL_SCALE);
  assign fits       = (rem >= dvs);
  assign quo_step   = {quo[LEVEL_W-2:0], fits};
  assign fin_level  = (state == BK_DIV) ? quo_step : '0;

  // Colour bands; a full-scale level keeps the previous colour
  always_comb begin
    colour_new = colour_held;
    priority if (fin_level <= RED_MAX) begin
      colour_new = COL_RED;
    end else if (fin_level <= YELLOW_MAX) begin
      colour_new = COL_YELLOW;
    end else if (fin_level <= GREEN_MAX) begin
      colour_new = COL_GREEN;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:  if (take && needs_div) state_next = BK_SCALE;
      BK_SCALE: state_next = BK_PREP;
      BK_PREP:  state_next = zero_level ? BK_IDLE : BK_DIV;
      BK_DIV:   if (step == '0) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  // Outputs of the control
  always_comb begin
    needs_div = q_tick.done_res && (q_tick.status == ST_OK);
    take      = (state == BK_IDLE) && !q_empty && (!out_valid || pop);
    q_pop     = take;
    finish    = ((state == BK_PREP) && zero_level) || ((state == BK_DIV) && (step == '0));
    load      = (take && !needs_div) || finish;
    if (finish) begin
      res_next = '{tick_hold.trigger_out, tick_hold.busy_res, tick_hold.done_res,
                   tick_hold.status, fin_level, colour_new};
    end else begin
      res_next = '{q_tick.trigger_out, q_tick.busy_res, q_tick.done_res,
                   q_tick.status, level_held, colour_held};
    end
  end

  // Level datapath: scale, form numerator, restoring divide
  always_ff @(posedge clk) begin
    if (take) begin
      tick_hold  <= q_tick;
      width_hold <= q_width;
    end
    unique case (state)
      BK_SCALE: begin
        full_r <= FULL_W'(tank_h) * FULL_W'(US_PER_MM_X10);
        used_r <= CMP_W'(width_hold) * CMP_W'(WIDTH_SCALE);
      end
      BK_PREP: begin
        rem  <= num;
        dvs  <= NUM_W'(full_r) << (DIV_STEPS - 1);
        quo  <= '0;
        step <= STEP_W'(DIV_STEPS - 1);
      end
      BK_DIV: begin
        if (fits) begin
          rem <= rem - dvs;
        end
        dvs  <= dvs >> 1;
        quo  <= quo_step;
        step <= step - 1'b1;
      end
      default: begin
      end
    endcase
    if (load) begin
      result <= res_next;
    end
  end

  // Control state and held level/colour
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      out_valid   <= 1'b0;
      level_held  <= '0;
      colour_held <= COL_OFF;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (finish) begin
        level_held  <= fin_level;
        colour_held <= colour_new;
      end
    end
  end

  `AST_IMPL(a_out_free, clk, rst, state == BK_PREP || state == BK_DIV, !out_valid)
  `AST_NEXT(a_div_step, clk, rst, state == BK_DIV && step != '0, state == BK_DIV && step == $past(step) - STEP_W'(1))

endmodule

`default_nettype wire
